/* hdl/skt_pkg.sv */
// Shared types, constants and helpers for the sorted key table search block.
`default_nettype none
package skt_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int KEY_BITS    = 16;

	localparam int SLOT_W  = $clog2(TABLE_DEPTH);
	localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int KEY_W   = KEY_BITS;
	localparam int IDX_W   = COUNT_W;

	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic wr;
		logic load;
		logic probe;
		logic step;
		logic emit_hit;
		logic emit_miss;
	} skt_cmd_t;

	typedef struct packed {
		logic range_ok;
		logic hit;
		logic next_ok;
	} skt_stat_t;

	// floor((lo + hi - 1) / 2), valid while lo < hi
	function automatic idx_t mid_of(input idx_t lo, input idx_t hi);
		logic [IDX_W:0] sum;
		sum = {1'b0, lo} + {1'b0, hi} - {{IDX_W{1'b0}}, 1'b1};
		return sum[IDX_W:1];
	endfunction

endpackage
`default_nettype wire

/* hdl/skt_ram.sv */
// Generic single-port RAM with registered read.
`default_nettype none
module skt_ram #(
	parameter int WIDTH  = 16,
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire logic [WIDTH-1:0]  wdata,
	output logic      [WIDTH-1:0]  rdata_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

endmodule
`default_nettype wire

/* hdl/skt_ctrl.sv */
// Search controller: sequences table writes and the probe loop of a lookup.
`default_nettype none
module skt_ctrl
	import skt_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire logic      kind,
	input  skt_stat_t      stat,
	output skt_cmd_t       cmd,
	output logic           busy_q
);

	typedef enum logic [1:0] {ST_IDLE, ST_PROBE, ST_CHECK} state_t;

	state_t state_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.wr   = start && (kind == KIND_WRITE);
				cmd.load = start && (kind == KIND_LOOKUP);
			end
			ST_PROBE: begin
				cmd.probe     = stat.range_ok;
				cmd.emit_miss = !stat.range_ok;
			end
			ST_CHECK: begin
				cmd.emit_hit  = stat.hit;
				cmd.step      = !stat.hit;
				cmd.emit_miss = !stat.hit && !stat.next_ok;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_PROBE;
						busy_q  <= 1'b1;
					end
				end
				ST_PROBE: begin
					if (cmd.probe) begin
						state_q <= ST_CHECK;
					end else begin
						state_q <= ST_IDLE;
						busy_q  <= 1'b0;
					end
				end
				ST_CHECK: begin
					if (cmd.emit_hit || cmd.emit_miss) begin
						state_q <= ST_IDLE;
						busy_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	a_busy_state: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q == (state_q != ST_IDLE))
		else $error("busy disagrees with state");

	a_one_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.emit_hit && cmd.emit_miss))
		else $error("hit and miss emitted together");

	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |-> !busy_q)
		else $error("table write during a lookup");

endmodule
`default_nettype wire

/* hdl/skt_dp.sv */
// Search datapath: count register, key table, range registers and result word.
`default_nettype none
module skt_dp
	import skt_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [COUNT_W-1:0] cfg_wdata,
	input  wire logic [SLOT_W-1:0] entry_index,
	input  wire logic [KEY_W-1:0]  key,
	input  skt_cmd_t               cmd,
	output skt_stat_t              stat,
	output logic                   done_q,
	output logic                   found_q,
	output logic [SLOT_W-1:0]      match_index_q
);

	localparam int ADDR_W = $clog2(TABLE_DEPTH);

	logic [COUNT_W-1:0]  cnt_q;
	idx_t                lo_q;
	idx_t                hi_q;
	idx_t                mid_q;
	logic [KEY_BITS-1:0] key_q;
	logic [KEY_BITS-1:0] key_m;
	logic [KEY_BITS-1:0] rdata;
	idx_t                used_c;
	idx_t                mid_c;
	idx_t                lo_n;
	idx_t                hi_n;
	idx_t                mid_n;
	logic                lt;
	logic                slot_ok;
	logic [ADDR_W-1:0]   addr;

	assign key_m   = KEY_BITS'(key);
	assign slot_ok = 32'(entry_index) < TABLE_DEPTH;
	assign used_c  = (32'(cnt_q) > TABLE_DEPTH) ? IDX_W'(TABLE_DEPTH) : cnt_q;

	assign mid_c = mid_of(lo_q, hi_q);
	assign lt    = key_q < rdata;
	assign lo_n  = lt ? lo_q : mid_q + idx_t'(1);
	assign hi_n  = lt ? mid_q : hi_q;
	assign mid_n = mid_of(lo_n, hi_n);

	assign stat.range_ok = lo_q < hi_q;
	assign stat.hit      = rdata == key_q;
	assign stat.next_ok  = lo_n < hi_n;

	always_comb begin
		if (cmd.wr) begin
			addr = ADDR_W'(entry_index);
		end else if (cmd.step) begin
			addr = ADDR_W'(mid_n);
		end else begin
			addr = ADDR_W'(mid_c);
		end
	end

	skt_ram #(
		.WIDTH (KEY_BITS),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (cmd.wr && slot_ok),
		.addr    (addr),
		.wdata   (key_m),
		.rdata_q (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			lo_q   <= '0;
			hi_q   <= '0;
			done_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cnt_q <= cfg_wdata;
			end
			if (cmd.load) begin
				lo_q <= '0;
				hi_q <= used_c;
			end else if (cmd.step) begin
				lo_q <= lo_n;
				hi_q <= hi_n;
			end
			done_q <= cmd.emit_hit || cmd.emit_miss;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= key_m;
		end
		if (cmd.probe) begin
			mid_q <= mid_c;
		end else if (cmd.step) begin
			mid_q <= mid_n;
		end
		if (cmd.emit_hit) begin
			found_q       <= 1'b1;
			match_index_q <= SLOT_W'(mid_q);
		end else if (cmd.emit_miss) begin
			found_q       <= 1'b0;
			match_index_q <= '0;
		end
	end

endmodule
`default_nettype wire

/* hdl/sorted_key_table_binary_search.sv */
// Top level of the sorted key table with binary search lookup.
// A write word (kind 0) stores key at entry_index and busy stays low.
// A lookup word (kind 1) raises busy and runs a binary search over the first
// entry_count entries: a setup step, then one probe per cycle against the
// single-port key memory, at most floor(log2(count)) + 1 probes (11 for 1024
// entries). The result word is shown for exactly one cycle with done high,
// in the same cycle that busy falls; the receiver cannot stall it. The user
// must write entry_count through cfg_we and cfg_wdata only while no lookup is
// running; the block itself does not enforce it.
`default_nettype none
module sorted_key_table_binary_search
	import skt_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [COUNT_W-1:0] cfg_wdata,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               kind,
	input  wire logic [SLOT_W-1:0]  entry_index,
	input  wire logic [KEY_W-1:0]   key,
	output logic                    done,
	output logic                    found,
	output logic [SLOT_W-1:0]       match_index
);

	skt_cmd_t  cmd;
	skt_stat_t stat;

	skt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.stat   (stat),
		.cmd    (cmd),
		.busy_q (busy)
	);

	skt_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.entry_index   (entry_index),
		.key           (key),
		.cmd           (cmd),
		.stat          (stat),
		.done_q        (done),
		.found_q       (found),
		.match_index_q (match_index)
	);

	a_lookup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind == KIND_LOOKUP) |=> busy)
		else $error("lookup accepted without going busy");

	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("lookup ended without a result word");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result word while busy");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !found) |-> match_index == '0)
		else $error("nonzero index on a miss");

endmodule
`default_nettype wire
